/* hw/rtl/pngc_pkg.sv */
// shared types, constants and the bytewise crc-32 update for the png stream carver
`default_nettype none

package pngc_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned OUT_OFF_W       = 32;
  localparam int unsigned CFG_W           = 32;

  localparam logic [63:0] PNG_SIGNATURE = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] TYPE_IEND     = 32'h4945_4E44;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

  typedef enum logic [4:0] {
    MODE_SEARCH = 5'b00001,
    MODE_LENGTH = 5'b00010,
    MODE_TYPE   = 5'b00100,
    MODE_DATA   = 5'b01000,
    MODE_CRC    = 5'b10000
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_COMPLETE = 2'd0,
    STATUS_CRC_BAD  = 2'd1,
    STATUS_TOO_BIG  = 2'd2,
    STATUS_STREAM   = 2'd3
  } status_t;

  typedef struct packed {
    logic [OUT_OFF_W-1:0] image_start;
    logic [OUT_OFF_W-1:0] image_end;
    status_t              end_status;
    logic                 needs_trailer;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pngc_parser.sv */
// signature search and chunk walk, one byte per accepted item
`default_nettype none

module pngc_parser import pngc_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             acc,
  input  wire logic [7:0]       data_byte,
  input  wire logic             end_of_stream,
  input  wire logic [CFG_W-1:0] stream_length,
  output logic                  res_valid,
  output result_t               res
);

  localparam int unsigned SUM_W = ((OFFSET_BITS > CFG_W) ? OFFSET_BITS : CFG_W) + 1;

  mode_t                  mode, mode_next;
  logic [63:0]            window, window_next;
  logic [OFFSET_BITS-1:0] position, position_next;
  logic [OFFSET_BITS-1:0] start_offset, start_offset_next;
  logic [OFFSET_BITS-1:0] last_good_end, last_good_end_next;
  logic [31:0]            bytes_left, bytes_left_next;
  logic [1:0]             field_cnt, field_cnt_next;
  logic [31:0]            running_crc, running_crc_next;
  logic [31:0]            stored_crc, stored_crc_next;
  logic [31:0]            type_word, type_word_next;

  logic                   emit;
  logic [OFFSET_BITS-1:0] end_val;
  status_t                status;
  logic [OFFSET_BITS-1:0] nextpos;
  logic                   too_big;

  assign nextpos = position + 1'b1;
  assign too_big = (bytes_left != 32'd0) &&
                   ((SUM_W'(bytes_left) + SUM_W'(nextpos)) > SUM_W'(stream_length));

  always_comb begin
    mode_next          = mode;
    window_next        = window;
    position_next      = nextpos;
    start_offset_next  = start_offset;
    last_good_end_next = last_good_end;
    bytes_left_next    = bytes_left;
    field_cnt_next     = field_cnt;
    running_crc_next   = running_crc;
    stored_crc_next    = stored_crc;
    type_word_next     = type_word;
    emit               = 1'b0;
    end_val            = last_good_end;
    status             = STATUS_COMPLETE;

    unique case (mode)
      MODE_LENGTH: begin
        bytes_left_next = {bytes_left[23:0], data_byte};
        if (field_cnt == 2'd3) begin
          field_cnt_next   = 2'd0;
          mode_next        = MODE_TYPE;
          running_crc_next = CRC_INIT;
        end else begin
          field_cnt_next = field_cnt + 2'd1;
        end
      end
      MODE_TYPE: begin
        type_word_next   = {type_word[23:0], data_byte};
        running_crc_next = crc_byte(running_crc, data_byte);
        if (field_cnt == 2'd3) begin
          field_cnt_next = 2'd0;
          if (too_big) begin
            emit   = 1'b1;
            status = STATUS_TOO_BIG;
          end else begin
            mode_next = (bytes_left == 32'd0) ? MODE_CRC : MODE_DATA;
          end
        end else begin
          field_cnt_next = field_cnt + 2'd1;
        end
      end
      MODE_DATA: begin
        running_crc_next = crc_byte(running_crc, data_byte);
        bytes_left_next  = bytes_left - 32'd1;
        if (bytes_left == 32'd1) begin
          mode_next      = MODE_CRC;
          field_cnt_next = 2'd0;
        end
      end
      MODE_CRC: begin
        stored_crc_next = {stored_crc[23:0], data_byte};
        if (field_cnt == 2'd3) begin
          field_cnt_next = 2'd0;
          if (~running_crc != stored_crc_next) begin
            emit   = 1'b1;
            status = STATUS_CRC_BAD;
          end else if (type_word == TYPE_IEND) begin
            emit    = 1'b1;
            end_val = nextpos;
            status  = STATUS_COMPLETE;
          end else begin
            last_good_end_next = nextpos;
            mode_next          = MODE_LENGTH;
          end
        end else begin
          field_cnt_next = field_cnt + 2'd1;
        end
      end
      default: begin
        window_next = {window[55:0], data_byte};
        mode_next   = MODE_SEARCH;
        if (window_next == PNG_SIGNATURE) begin
          start_offset_next  = position - OFFSET_BITS'(7);
          last_good_end_next = nextpos;
          mode_next          = MODE_LENGTH;
          window_next        = 64'd0;
          field_cnt_next     = 2'd0;
          bytes_left_next    = 32'd0;
        end
      end
    endcase

    if (emit) begin
      mode_next      = MODE_SEARCH;
      window_next    = 64'd0;
      field_cnt_next = 2'd0;
    end else if (end_of_stream && (mode_next != MODE_SEARCH)) begin
      emit    = 1'b1;
      end_val = last_good_end_next;
      status  = STATUS_STREAM;
    end

    if (end_of_stream) begin
      mode_next      = MODE_SEARCH;
      window_next    = 64'd0;
      field_cnt_next = 2'd0;
      position_next  = '0;
    end
  end

  assign res_valid         = acc && emit;
  assign res.image_start   = OUT_OFF_W'(start_offset_next);
  assign res.image_end     = OUT_OFF_W'(end_val);
  assign res.end_status    = status;
  assign res.needs_trailer = (status != STATUS_COMPLETE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_SEARCH;
      window        <= 64'd0;
      position      <= '0;
      start_offset  <= '0;
      last_good_end <= '0;
      bytes_left    <= 32'd0;
      field_cnt     <= 2'd0;
      running_crc   <= CRC_INIT;
      stored_crc    <= 32'd0;
      type_word     <= 32'd0;
    end else if (acc) begin
      mode          <= mode_next;
      window        <= window_next;
      position      <= position_next;
      start_offset  <= start_offset_next;
      last_good_end <= last_good_end_next;
      bytes_left    <= bytes_left_next;
      field_cnt     <= field_cnt_next;
      running_crc   <= running_crc_next;
      stored_crc    <= stored_crc_next;
      type_word     <= type_word_next;
    end
  end

  a_eos_restarts: assert property (@(posedge clk) disable iff (rst)
    acc && end_of_stream |=> (mode == MODE_SEARCH) && (position == '0) && (window == 64'd0))
    else $error("stream end did not restart the search");

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_DATA) |-> (bytes_left != 32'd0))
    else $error("data mode with no bytes left");

  a_eos_emits_when_parsing: assert property (@(posedge clk) disable iff (rst)
    acc && end_of_stream && (mode != MODE_SEARCH) |-> res_valid)
    else $error("open image dropped at stream end");

  a_search_field_cnt: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_SEARCH) |-> (field_cnt == 2'd0))
    else $error("field count not cleared while searching");

endmodule

`default_nettype wire

/* hw/rtl/pngc_skid.sv */
// two-entry result buffer: output register plus skid stage
`default_nettype none

module pngc_skid import pngc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && out_ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end else if (pop && skid_valid) begin
      out_data <= skid_data;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while output is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("item pushed into a full buffer");

endmodule

`default_nettype wire

/* hw/rtl/png_stream_carver.sv */
// top level of the png stream carver: config register, parser and result buffer
// throughput: one byte item per cycle; s_tready drops only while two results wait
// a result is registered in the output register, or the skid stage while that is held
// the parser state and the crc update sit between the input port and the result register
// reset: parser returns to signature search at offset 0, stream_length becomes all ones
// reset empties the result buffer; no clearing pass is needed
`default_nettype none

module png_stream_carver import pngc_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // data_byte
  input  wire logic             s_tlast,   // end_of_stream
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [63:0]           m_tdata,   // image_start, image_end
  output logic [2:0]            m_tuser,   // end_status, needs_trailer
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data   // stream_length
);

  logic [CFG_W-1:0] stream_length;
  logic             acc;
  logic             res_valid;
  result_t          res;
  logic             full;
  result_t          out_data;

  assign cfg_ready = 1'b1;
  assign s_tready  = !full;
  assign acc       = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_length <= '1;
    end else if (cfg_valid && cfg_ready) begin
      stream_length <= cfg_data;
    end
  end

  pngc_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .acc           (acc),
    .data_byte     (s_tdata),
    .end_of_stream (s_tlast),
    .stream_length (stream_length),
    .res_valid     (res_valid),
    .res           (res)
  );

  pngc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {out_data.image_end, out_data.image_start};
  assign m_tuser = {out_data.needs_trailer, out_data.end_status};

endmodule

`default_nettype wire
